// ===== design/bhtdu_pkg.sv =====
// Shared types and constants for the beam hit timestamp delta unpacker.
// No dependencies; every other design file imports this package.
`default_nettype none

package bhtdu_pkg;

    // Width of a section header's hit count field.
    localparam int HIT_COUNT_BITS = 13;

    // Front-to-back queue depth; kept a power of two so the pointers wrap naturally.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [2:0] CFG_PREAMBLE_WORDS   = 3'd0;
    localparam logic [2:0] CFG_DELTA_CAP        = 3'd1;
    localparam logic [2:0] CFG_FIRST_HEADER_ID  = 3'd2;
    localparam logic [2:0] CFG_SECOND_HEADER_ID = 3'd3;
    localparam logic [2:0] CFG_TRAILER_ID       = 3'd4;

    // Configuration reset values.
    localparam logic [7:0]  PREAMBLE_WORDS_RST   = 8'd23;
    localparam logic [31:0] DELTA_CAP_RST        = 32'd100000000;
    localparam logic [15:0] FIRST_HEADER_ID_RST  = 16'hAAAA;
    localparam logic [15:0] SECOND_HEADER_ID_RST = 16'hBBBB;
    localparam logic [15:0] TRAILER_ID_RST       = 16'hCCCC;

    typedef logic [HIT_COUNT_BITS-1:0] count_t;

    // Parse phase; the word kind reported for a word equals the phase it is parsed in.
    typedef enum logic [2:0] {
        PH_PREAMBLE = 3'd0,
        PH_HEAD1    = 3'd1,
        PH_HITS1    = 3'd2,
        PH_HEAD2    = 3'd3,
        PH_HITS2    = 3'd4,
        PH_TRAILER  = 3'd5,
        PH_DONE     = 3'd6
    } phase_t;

    typedef struct packed {
        logic [7:0]  preamble_words;
        logic [31:0] delta_cap;
        logic [15:0] first_header_id;
        logic [15:0] second_header_id;
        logic [15:0] trailer_id;
    } cfg_t;

    typedef struct packed {
        logic [31:0] data_word;
        logic        start_event;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  word_kind;
        logic [12:0] hit_index;
        logic [31:0] time_delta;
        logic        delta_valid;
        logic        id_error;
        logic [31:0] error_total;
        logic [63:0] first_sum;
        logic [63:0] second_sum;
        logic [31:0] event_total;
    } out_beat_t;

    // Classified word handed from the front to the back.
    typedef struct packed {
        phase_t      kind;
        count_t      index;
        logic [31:0] word;
        logic        first_hit;
        logic        id_err;
        logic        start;
    } op_t;

endpackage

`default_nettype wire

// ===== design/bhtdu_front.sv =====
// Front end: parse-phase state machine that classifies each accepted word.
// Depends on bhtdu_pkg.
`default_nettype none

module bhtdu_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bhtdu_pkg::in_beat_t  s_data,
    input  bhtdu_pkg::cfg_t      cfg,
    output logic                 op_valid,
    output bhtdu_pkg::op_t       op_data,
    input  logic                 op_ready
);
    import bhtdu_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] pre_left_reg, pre_left_next;
    count_t     hits_left_reg, hits_left_next;
    count_t     hit_pos_reg, hit_pos_next;
    logic       first_pend_reg, first_pend_next;

    logic       accept;
    phase_t     phase_s;
    phase_t     phase_w;
    logic [7:0] pre_left_s;
    count_t     hdr_count;
    logic       hits_done;

    assign accept     = s_valid && op_ready;
    // A start word reloads the preamble before the word itself is parsed.
    assign phase_s    = s_data.start_event ? PH_PREAMBLE : phase_reg;
    assign pre_left_s = s_data.start_event ? cfg.preamble_words : pre_left_reg;
    assign phase_w    = (phase_s == PH_PREAMBLE && pre_left_s == 8'd0) ? PH_HEAD1 : phase_s;
    assign hdr_count  = s_data.data_word[HIT_COUNT_BITS-1:0];
    assign hits_done  = (hits_left_reg == count_t'(1));

    // Next state
    always_comb begin
        phase_next      = phase_reg;
        pre_left_next   = pre_left_reg;
        hits_left_next  = hits_left_reg;
        hit_pos_next    = hit_pos_reg;
        first_pend_next = first_pend_reg;
        if (accept) begin
            phase_next    = phase_w;
            pre_left_next = pre_left_s;
            case (phase_w)
                PH_PREAMBLE: begin
                    pre_left_next = pre_left_s - 8'd1;
                end
                PH_HEAD1: begin
                    hits_left_next  = hdr_count;
                    hit_pos_next    = '0;
                    first_pend_next = 1'b1;
                    phase_next      = (hdr_count == '0) ? PH_HEAD2 : PH_HITS1;
                end
                PH_HEAD2: begin
                    hits_left_next  = hdr_count;
                    hit_pos_next    = '0;
                    first_pend_next = 1'b1;
                    phase_next      = (hdr_count == '0) ? PH_TRAILER : PH_HITS2;
                end
                PH_HITS1: begin
                    first_pend_next = 1'b0;
                    hit_pos_next    = hit_pos_reg + count_t'(1);
                    hits_left_next  = hits_left_reg - count_t'(1);
                    if (hits_done) phase_next = PH_HEAD2;
                end
                PH_HITS2: begin
                    first_pend_next = 1'b0;
                    hit_pos_next    = hit_pos_reg + count_t'(1);
                    hits_left_next  = hits_left_reg - count_t'(1);
                    if (hits_done) phase_next = PH_TRAILER;
                end
                PH_TRAILER: begin
                    phase_next = PH_DONE;
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    // Outputs
    always_comb begin
        op_valid          = s_valid;
        s_ready           = op_ready;
        op_data.kind      = phase_w;
        op_data.word      = s_data.data_word;
        op_data.start     = s_data.start_event;
        op_data.first_hit = first_pend_reg;
        op_data.index     = '0;
        op_data.id_err    = 1'b0;
        case (phase_w)
            PH_HEAD1:   op_data.id_err = (s_data.data_word[31:16] != cfg.first_header_id);
            PH_HEAD2:   op_data.id_err = (s_data.data_word[31:16] != cfg.second_header_id);
            PH_TRAILER: op_data.id_err = (s_data.data_word[31:16] != cfg.trailer_id);
            PH_HITS1,
            PH_HITS2:   op_data.index  = hit_pos_reg;
            default:    op_data.id_err = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_PREAMBLE;
            pre_left_reg   <= '0;
            hits_left_reg  <= '0;
            hit_pos_reg    <= '0;
            first_pend_reg <= 1'b1;
        end else begin
            phase_reg      <= phase_next;
            pre_left_reg   <= pre_left_next;
            hits_left_reg  <= hits_left_next;
            hit_pos_reg    <= hit_pos_next;
            first_pend_reg <= first_pend_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/bhtdu_queue.sv =====
// Short FIFO of classified words between front and back.
// Depends on bhtdu_pkg.
`default_nettype none

module bhtdu_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  bhtdu_pkg::op_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output bhtdu_pkg::op_t  out_data
);
    import bhtdu_pkg::*;

    op_t                    entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   push;
    logic                   pop;

    assign in_ready  = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) count_next = count_reg + QUEUE_CNT_W'(1);
        if (pop && !push) count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (push) entries_reg[wr_ptr_reg] <= in_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/bhtdu_back.sv =====
// Back end: timestamp difference, wrap and cap, running sums and counters,
// and the registered result stage. Depends on bhtdu_pkg.
`default_nettype none

module bhtdu_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  op_valid,
    output logic                  op_ready,
    input  bhtdu_pkg::op_t        op_data,
    input  bhtdu_pkg::cfg_t       cfg,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bhtdu_pkg::out_beat_t  m_data
);
    import bhtdu_pkg::*;

    logic [31:0] prev_ts_reg, prev_ts_next;
    logic [63:0] sum1_reg, sum1_next;
    logic [63:0] sum2_reg, sum2_next;
    logic [31:0] err_cnt_reg, err_cnt_next;
    logic [31:0] evt_cnt_reg, evt_cnt_next;
    logic        m_valid_reg, m_valid_next;
    out_beat_t   m_data_reg, m_data_next;

    logic        pop;
    logic        is_hit;
    logic        counted;
    logic [31:0] raw_delta;
    logic [31:0] wrap_delta;
    logic [31:0] delta;

    assign pop      = op_valid && (!m_valid_reg || m_ready);
    assign op_ready = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign is_hit     = (op_data.kind == PH_HITS1) || (op_data.kind == PH_HITS2);
    assign counted    = is_hit && !op_data.first_hit;
    assign raw_delta  = op_data.word - prev_ts_reg;
    // A backward step wraps by 2^32 - 1, i.e. one less than the modular difference.
    assign wrap_delta = raw_delta - 32'd1;

    always_comb begin
        if (!counted) begin
            delta = '0;
        end else if (op_data.word >= prev_ts_reg) begin
            delta = raw_delta;
        end else if (wrap_delta > cfg.delta_cap) begin
            delta = '0;
        end else begin
            delta = wrap_delta;
        end
    end

    always_comb begin
        prev_ts_next = prev_ts_reg;
        sum1_next    = sum1_reg;
        sum2_next    = sum2_reg;
        err_cnt_next = err_cnt_reg;
        evt_cnt_next = evt_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (pop) begin
            if (op_data.start) evt_cnt_next = evt_cnt_reg + 32'd1;
            if (op_data.id_err) err_cnt_next = err_cnt_reg + 32'd1;
            if (is_hit) prev_ts_next = op_data.word;
            if (counted && op_data.kind == PH_HITS1) sum1_next = sum1_reg + 64'(delta);
            if (counted && op_data.kind == PH_HITS2) sum2_next = sum2_reg + 64'(delta);
            m_valid_next            = 1'b1;
            m_data_next.word_kind   = op_data.kind;
            m_data_next.hit_index   = 13'(op_data.index);
            m_data_next.time_delta  = delta;
            m_data_next.delta_valid = counted;
            m_data_next.id_error    = op_data.id_err;
            m_data_next.error_total = err_cnt_next;
            m_data_next.first_sum   = sum1_next;
            m_data_next.second_sum  = sum2_next;
            m_data_next.event_total = evt_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_ts_reg <= '0;
            sum1_reg    <= '0;
            sum2_reg    <= '0;
            err_cnt_reg <= '0;
            evt_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            prev_ts_reg <= prev_ts_next;
            sum1_reg    <= sum1_next;
            sum2_reg    <= sum2_next;
            err_cnt_reg <= err_cnt_next;
            evt_cnt_reg <= evt_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/beam_hit_timestamp_delta_unpacker.sv =====
// Path: an accepted word is written into the queue; the back then takes it from the
//   queue into the registered result stage that drives m_.
// Throughput: one word per cycle, sustained, while m_ready stays high; the front
//   state machine and the back accumulator each retire one word per clock.
// Reset (aresetn low, synchronous): parser returns to the preamble phase with nothing
//   left to skip, all totals and the previous timestamp clear, config takes reset values.
// Depends on bhtdu_pkg, bhtdu_front, bhtdu_queue, bhtdu_back.
`default_nettype none

module beam_hit_timestamp_delta_unpacker (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Word input channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bhtdu_pkg::in_beat_t   s_data,
    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output bhtdu_pkg::out_beat_t  m_data,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data
);
    import bhtdu_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic front_valid;
    logic front_ready;
    op_t  front_op;
    logic back_valid;
    logic back_ready;
    op_t  back_op;

    // Configuration registers; an index past the register list is dropped. Writes must
    // land only while the block is idle (no shadow copy): the user's rule, not enforced.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_PREAMBLE_WORDS:   cfg_next.preamble_words   = cfg_data[7:0];
                CFG_DELTA_CAP:        cfg_next.delta_cap        = cfg_data;
                CFG_FIRST_HEADER_ID:  cfg_next.first_header_id  = cfg_data[15:0];
                CFG_SECOND_HEADER_ID: cfg_next.second_header_id = cfg_data[15:0];
                CFG_TRAILER_ID:       cfg_next.trailer_id       = cfg_data[15:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.preamble_words   <= PREAMBLE_WORDS_RST;
            cfg_reg.delta_cap        <= DELTA_CAP_RST;
            cfg_reg.first_header_id  <= FIRST_HEADER_ID_RST;
            cfg_reg.second_header_id <= SECOND_HEADER_ID_RST;
            cfg_reg.trailer_id       <= TRAILER_ID_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: classify each beat by parse phase (preamble, header, hit, trailer)
    // and check header/trailer IDs. It needs nothing from the back, so it only
    // stalls when the queue is full.
    bhtdu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .cfg      (cfg_reg),
        .op_valid (front_valid),
        .op_ready (front_ready),
        .op_data  (front_op)
    );

    // Queue: absorb a beat while the result register waits on m_ready.
    bhtdu_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_op),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_data  (back_op)
    );

    // Back: difference to the previous timestamp (kept across sections and
    // subevents), wrap and cap, 64-bit sums, error and subevent counts, and
    // the output register.
    bhtdu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (back_valid),
        .op_ready (back_ready),
        .op_data  (back_op),
        .cfg      (cfg_reg),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

// ===== design/bhtdu_checker.sv =====
// Port-level checks for the unpacker, bound to the top level.
// Depends on bhtdu_pkg and beam_hit_timestamp_delta_unpacker.
`default_nettype none

module bhtdu_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input bhtdu_pkg::out_beat_t  m_data
);
    import bhtdu_pkg::*;

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // A difference is only reported on a hit.
    a_delta_on_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.delta_valid |->
            m_data.word_kind == PH_HITS1 || m_data.word_kind == PH_HITS2)
        else $error("delta_valid on a word that is not a hit");

    // Without a valid difference the difference reads zero.
    a_delta_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.delta_valid |-> m_data.time_delta == 32'd0)
        else $error("time_delta nonzero without delta_valid");

    // ID errors come only from headers and the trailer; the property leaves the total aside.
    a_id_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.id_error |->
            m_data.word_kind == PH_HEAD1 || m_data.word_kind == PH_HEAD2 ||
            m_data.word_kind == PH_TRAILER)
        else $error("id_error on a word that is not a header or trailer");

    // No result beat in the cycle after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind beam_hit_timestamp_delta_unpacker bhtdu_checker u_bhtdu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

// ===== tb/tb_beam_hit_timestamp_delta_unpacker.sv =====
// Self-checking testbench for beam_hit_timestamp_delta_unpacker: directed and random
// subevent streams, checked beat by beat against an in-bench parser model.
// Depends on bhtdu_pkg and the unpacker RTL only.
module tb_beam_hit_timestamp_delta_unpacker;
    timeunit 1ns;
    timeprecision 1ps;

    import bhtdu_pkg::*;

    // Cycles with no beat on any channel before the run is declared hung.
    localparam int STALL_LIMIT = 5000;
    // Cap on printed fault lines; every fault is still counted.
    localparam int PRINT_LIMIT = 40;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_beat_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_beat_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    beam_hit_timestamp_delta_unpacker uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Parser model state: a shadow of the register file and of the
    // block's parse state, advanced once per accepted input beat.
    // ------------------------------------------------------------------
    cfg_t        unpacker_cfg;
    phase_t      cur_phase;
    logic [7:0]  preamble_left;
    count_t      hits_left;
    count_t      hit_pos;
    logic        first_pending;
    logic [31:0] prev_stamp;
    logic [63:0] sum_first;
    logic [63:0] sum_second;
    logic [31:0] id_fault_count;
    logic [31:0] subevent_count;

    // Parsed results waiting for their beat on m_, oldest first.
    out_beat_t   unpacked_words[$];

    // Stimulus knobs and bookkeeping.
    int          feed_idle_pct;
    int          sink_idle_pct;
    int          words_sent;
    int          results_seen;
    int          capped_deltas;
    int          check_failures;
    int          quiet_cycles;
    logic [31:0] gen_stamp;

    task automatic reset_model();
        unpacker_cfg.preamble_words   = PREAMBLE_WORDS_RST;
        unpacker_cfg.delta_cap        = DELTA_CAP_RST;
        unpacker_cfg.first_header_id  = FIRST_HEADER_ID_RST;
        unpacker_cfg.second_header_id = SECOND_HEADER_ID_RST;
        unpacker_cfg.trailer_id       = TRAILER_ID_RST;
        cur_phase      = PH_PREAMBLE;
        preamble_left  = '0;
        hits_left      = '0;
        hit_pos        = '0;
        first_pending  = 1'b1;
        prev_stamp     = '0;
        sum_first      = '0;
        sum_second     = '0;
        id_fault_count = '0;
        subevent_count = '0;
    endtask

    // Timestamp difference with rollover repair: a backward step gets 2^32-1
    // added, and if that lands above the cap the difference is dropped to zero.
    function automatic logic [31:0] stamp_gap(input logic [31:0] stamp);
        logic [63:0] wrapped;
        if (stamp >= prev_stamp)
            return stamp - prev_stamp;
        wrapped = {32'd0, stamp} + 64'hFFFF_FFFF - {32'd0, prev_stamp};
        if (wrapped > {32'd0, unpacker_cfg.delta_cap}) begin
            capped_deltas++;
            return '0;
        end
        return wrapped[31:0];
    endfunction

    // Advance the parser model by one word and produce its result beat.
    task automatic unpack_word(input in_beat_t w, output out_beat_t r);
        phase_t      kind;
        logic [15:0] want_id;
        logic [31:0] gap;
        r    = '0;
        kind = PH_DONE;

        // A start marker restarts the subevent; the same word is then parsed.
        if (w.start_event) begin
            subevent_count++;
            preamble_left = unpacker_cfg.preamble_words;
            cur_phase     = PH_PREAMBLE;
        end

        if (cur_phase == PH_PREAMBLE) begin
            if (preamble_left != 0) begin
                preamble_left--;
                kind = PH_PREAMBLE;
            end else begin
                cur_phase = PH_HEAD1;
            end
        end

        if (kind == PH_DONE) begin
            case (cur_phase)
                PH_HEAD1, PH_HEAD2: begin
                    kind    = cur_phase;
                    want_id = (cur_phase == PH_HEAD1) ? unpacker_cfg.first_header_id
                                                      : unpacker_cfg.second_header_id;
                    if (w.data_word[31:16] != want_id) begin
                        r.id_error = 1'b1;
                        id_fault_count++;
                    end
                    hits_left     = w.data_word[HIT_COUNT_BITS-1:0];
                    hit_pos       = '0;
                    first_pending = 1'b1;
                    // An empty section skips straight to the next header or trailer.
                    cur_phase = (hits_left == 0) ? phase_t'(cur_phase + 3'd2)
                                                 : phase_t'(cur_phase + 3'd1);
                end
                PH_HITS1, PH_HITS2: begin
                    kind        = cur_phase;
                    r.hit_index = hit_pos;
                    if (!first_pending) begin
                        gap           = stamp_gap(w.data_word);
                        r.time_delta  = gap;
                        r.delta_valid = 1'b1;
                        if (cur_phase == PH_HITS1)
                            sum_first = sum_first + {32'd0, gap};
                        else
                            sum_second = sum_second + {32'd0, gap};
                    end
                    first_pending = 1'b0;
                    prev_stamp    = w.data_word;
                    hit_pos++;
                    hits_left--;
                    if (hits_left == 0)
                        cur_phase = phase_t'(cur_phase + 3'd1);
                end
                PH_TRAILER: begin
                    kind = PH_TRAILER;
                    if (w.data_word[31:16] != unpacker_cfg.trailer_id) begin
                        r.id_error = 1'b1;
                        id_fault_count++;
                    end
                    cur_phase = PH_DONE;
                end
                default: kind = PH_DONE;
            endcase
        end

        r.word_kind   = kind;
        r.error_total = id_fault_count;
        r.first_sum   = sum_first;
        r.second_sum  = sum_second;
        r.event_total = subevent_count;
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_fault(input string what, input logic [63:0] got,
                                input logic [63:0] want);
        check_failures++;
        if (check_failures <= PRINT_LIMIT)
            $display("%0t ns: result %0d %s: got 0x%0h, want 0x%0h",
                     $realtime, results_seen, what, got, want);
    endtask

    task automatic check_result(input out_beat_t got, input out_beat_t want);
        if (got.word_kind !== want.word_kind)
            report_fault("word_kind", 64'(got.word_kind), 64'(want.word_kind));
        if (got.hit_index !== want.hit_index)
            report_fault("hit_index", 64'(got.hit_index), 64'(want.hit_index));
        if (got.time_delta !== want.time_delta)
            report_fault("time_delta", 64'(got.time_delta), 64'(want.time_delta));
        if (got.delta_valid !== want.delta_valid)
            report_fault("delta_valid", 64'(got.delta_valid), 64'(want.delta_valid));
        if (got.id_error !== want.id_error)
            report_fault("id_error", 64'(got.id_error), 64'(want.id_error));
        if (got.error_total !== want.error_total)
            report_fault("error_total", 64'(got.error_total), 64'(want.error_total));
        if (got.first_sum !== want.first_sum)
            report_fault("first_sum", got.first_sum, want.first_sum);
        if (got.second_sum !== want.second_sum)
            report_fault("second_sum", got.second_sum, want.second_sum);
        if (got.event_total !== want.event_total)
            report_fault("event_total", 64'(got.event_total), 64'(want.event_total));
    endtask

    // Sample every channel at the rising edge. Apply register writes and
    // parse accepted words first, then retire the oldest parsed result.
    always @(posedge aclk) begin
        out_beat_t parsed;
        out_beat_t oldest;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PREAMBLE_WORDS:   unpacker_cfg.preamble_words   = cfg_data[7:0];
                    CFG_DELTA_CAP:        unpacker_cfg.delta_cap        = cfg_data;
                    CFG_FIRST_HEADER_ID:  unpacker_cfg.first_header_id  = cfg_data[15:0];
                    CFG_SECOND_HEADER_ID: unpacker_cfg.second_header_id = cfg_data[15:0];
                    CFG_TRAILER_ID:       unpacker_cfg.trailer_id       = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                unpack_word(s_data, parsed);
                unpacked_words.push_back(parsed);
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (unpacked_words.size() == 0) begin
                    report_fault("beat with nothing pending", 64'(m_data.word_kind), 64'd0);
                end else begin
                    oldest = unpacked_words.pop_front();
                    check_result(m_data, oldest);
                end
            end
        end
    end

    // Hang detector: count cycles in which no channel moves a beat.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timed out with %0d results outstanding", unpacked_words.size());
                $display("beam_hit_timestamp_delta_unpacker test failed");
                $finish;
            end
        end
    end

    // Result backpressure: drop ready on a random share of cycles.
    always @(negedge aclk) begin
        m_ready = (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);
    end

    // ------------------------------------------------------------------
    // Drivers (all called and returning at a falling edge)
    // ------------------------------------------------------------------
    function automatic in_beat_t beat(input logic [31:0] word, input logic start);
        in_beat_t b;
        b.data_word   = word;
        b.start_event = start;
        return b;
    endfunction

    // Send one word: idle at random, then hold valid and payload until accepted.
    task automatic send_word(input logic [31:0] word, input logic start);
        while ($urandom_range(99) < feed_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = beat(word, start);
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
        // Drop valid; a following send that does not idle raises it again in this same step.
        s_valid = 1'b0;
        words_sent++;
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Wait until every parsed result has come back, then let the pipe empty.
    task automatic settle();
        while (unpacked_words.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic load_settings(input logic [7:0] pre, input logic [31:0] cap,
                                 input logic [15:0] id_first, input logic [15:0] id_second,
                                 input logic [15:0] id_trailer);
        settle();
        write_reg(CFG_PREAMBLE_WORDS,   {24'd0, pre});
        write_reg(CFG_DELTA_CAP,        cap);
        write_reg(CFG_FIRST_HEADER_ID,  {16'd0, id_first});
        write_reg(CFG_SECOND_HEADER_ID, {16'd0, id_second});
        write_reg(CFG_TRAILER_ID,       {16'd0, id_trailer});
    endtask

    // Next hit timestamp: mostly forward steps, with repeats, backward steps,
    // jumps just below rollover (so the next step wraps) and wild values.
    function automatic logic [31:0] next_stamp();
        int pick;
        pick = $urandom_range(99);
        if (pick < 66)
            gen_stamp = gen_stamp + $urandom_range(1, 5000);
        else if (pick < 74)
            gen_stamp = gen_stamp;
        else if (pick < 84)
            gen_stamp = gen_stamp - $urandom_range(1, 3000);
        else if (pick < 93)
            gen_stamp = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        else
            gen_stamp = $urandom;
        return gen_stamp;
    endfunction

    function automatic logic [15:0] pick_id(input logic [15:0] want);
        return ($urandom_range(99) < 10) ? 16'($urandom_range(0, 65535)) : want;
    endfunction

    function automatic logic [12:0] pick_count();
        return ($urandom_range(99) < 6) ? 13'($urandom_range(7, 40))
                                        : 13'($urandom_range(0, 6));
    endfunction

    // Build one subevent (preamble, two sections, trailer, stray words), cut a
    // share of them short so the next start lands mid-parse, then send it.
    task automatic send_subevent();
        in_beat_t    words[$];
        logic [12:0] count;
        int          keep;
        words.push_back(beat($urandom, 1'b1));
        words.delete();
        for (int i = 0; i < unpacker_cfg.preamble_words; i++)
            words.push_back(beat($urandom, 1'b0));
        count = pick_count();
        words.push_back(beat({pick_id(unpacker_cfg.first_header_id),
                              3'($urandom_range(0, 7)), count}, 1'b0));
        for (int i = 0; i < count; i++)
            words.push_back(beat(next_stamp(), 1'b0));
        count = pick_count();
        words.push_back(beat({pick_id(unpacker_cfg.second_header_id),
                              3'($urandom_range(0, 7)), count}, 1'b0));
        for (int i = 0; i < count; i++)
            words.push_back(beat(next_stamp(), 1'b0));
        words.push_back(beat({pick_id(unpacker_cfg.trailer_id),
                              16'($urandom_range(0, 65535))}, 1'b0));
        repeat ($urandom_range(0, 2))
            words.push_back(beat($urandom, 1'b0));

        if ($urandom_range(99) < 12) begin
            keep = $urandom_range(1, words.size());
            while (words.size() > keep)
                void'(words.pop_back());
        end

        words[0].start_event = 1'b1;
        foreach (words[i])
            send_word(words[i].data_word, words[i].start_event);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values, no start marker: the first word is already a header.
    task automatic test_before_start();
        send_word(32'hAAAA_0002, 1'b0);
        send_word(32'h0000_0010, 1'b0);
        // Backward step at the reset cap: wraps above it, reported as zero.
        send_word(32'h0000_0005, 1'b0);
        // Wrong second header ID with an empty section.
        send_word(32'h1234_0000, 1'b0);
        send_word(32'hCCCC_0000, 1'b0);
        // Past the trailer: ignored.
        send_word(32'hFFFF_FFFF, 1'b0);
    endtask

    // Empty preamble, maximum cap, ID errors, extreme stamps and counts,
    // and a restart in the middle of a section.
    task automatic test_directed_subevents();
        load_settings(8'd0, 32'hFFFF_FFFF, FIRST_HEADER_ID_RST, SECOND_HEADER_ID_RST,
                      TRAILER_ID_RST);
        send_word(32'hBBBB_0001, 1'b1);
        send_word(32'h0000_0000, 1'b0);
        // Unused header bits set; they must not leak into the count.
        send_word(32'hBBBB_E003, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        // Rollover that wraps to exactly zero.
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h0000_FFFF, 1'b0);
        send_word(32'hAAAA_1FFF, 1'b1);
        send_word(32'h0000_0100, 1'b0);
        // Large backward step kept because the cap is at its top.
        send_word(32'h0000_0050, 1'b0);
        // Restart mid-section into two empty sections.
        send_word(32'hAAAA_0000, 1'b1);
        send_word(32'hBBBB_0000, 1'b0);
        send_word(32'hCCCC_FFFF, 1'b0);
        send_word(32'h5555_5555, 1'b0);
    endtask

    task automatic test_random_traffic(input int n_words, input logic [7:0] pre,
                                       input logic [31:0] cap, input logic [15:0] id_first,
                                       input logic [15:0] id_second,
                                       input logic [15:0] id_trailer);
        int target;
        load_settings(pre, cap, id_first, id_second, id_trailer);
        target = words_sent + n_words;
        while (words_sent < target)
            send_subevent();
    endtask

    // Longest preamble the register allows.
    task automatic test_long_preamble();
        load_settings(8'd255, 32'($urandom_range(0, 1000000)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        send_subevent();
    endtask

    initial begin
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        feed_idle_pct = 32;
        sink_idle_pct = 46;
        words_sent     = 0;
        results_seen   = 0;
        capped_deltas  = 0;
        check_failures = 0;
        quiet_cycles   = 0;
        gen_stamp      = $urandom;
        reset_model();

        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        test_before_start();
        test_directed_subevents();
        test_random_traffic(280, 8'd2, 32'd0, 16'h0000, 16'hFFFF,
                            16'($urandom_range(0, 65535)));

        feed_idle_pct = 46;
        sink_idle_pct = 32;
        test_random_traffic(280, 8'($urandom_range(1, 6)), 32'($urandom_range(500, 200000)),
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                            16'hFFFF);

        feed_idle_pct = 0;
        sink_idle_pct = 0;
        test_random_traffic(120, 8'd0, DELTA_CAP_RST, FIRST_HEADER_ID_RST,
                            SECOND_HEADER_ID_RST, 16'h0000);
        test_long_preamble();

        settle();
        repeat (8) @(posedge aclk);

        $display("Sent %0d words over %0d subevents; checked %0d result beats.",
                 words_sent, subevent_count, results_seen);
        $display("Model saw %0d header/trailer ID errors and %0d deltas capped to zero.",
                 id_fault_count, capped_deltas);
        if (check_failures == 0)
            $display("beam_hit_timestamp_delta_unpacker test passed");
        else
            $display("beam_hit_timestamp_delta_unpacker test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/bhtdu_pkg.sv
design/bhtdu_front.sv
design/bhtdu_queue.sv
design/bhtdu_back.sv
design/beam_hit_timestamp_delta_unpacker.sv
design/bhtdu_checker.sv
tb/tb_beam_hit_timestamp_delta_unpacker.sv
